FILE: rtl/pgtb_pkg.sv
// ----------------------------------------------------------------------------
// pgtb_pkg
// Shared types and constants for the proportional glyph tile blitter.
// ----------------------------------------------------------------------------
package pgtb_pkg;

  localparam int GLYPH_COUNT     = 96;
  localparam int FONT_PIXELS     = 16384;
  localparam int MAX_CHAR_WIDTH  = 16;
  localparam int MAX_ROWS        = 16;
  localparam int FIRST_CODE      = 32;
  localparam int LAST_CODE       = 127;

  localparam int FA_W = $clog2(FONT_PIXELS);
  localparam int GI_W = $clog2(GLYPH_COUNT);

  localparam logic [13:0] TILE_COLUMN_WORDS = 14'd320;
  localparam logic [13:0] SCREEN_WRAP_WORD  = 14'd9600;

  localparam logic [1:0] FUNC_LOAD_PIXEL = 2'd0;
  localparam logic [1:0] FUNC_LOAD_WIDTH = 2'd1;
  localparam logic [1:0] FUNC_SET_CURSOR = 2'd2;
  localparam logic [1:0] FUNC_DRAW       = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load_pixel;
    logic width_look;  // latch width load, read previous glyph's entries
    logic load_width;
    logic set_cursor;
    logic draw_setup;  // latch glyph, width, offset
    logic row_start;   // begin a column: clear row count, pixel word
    logic row_step;    // one font read issued / captured
    logic emit;        // present column result
    logic emit_bad;    // present bad-code result
  } pgtb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic bad;         // code has no glyph
    logic zero_width;
    logic rows_issued; // every row read of the column issued
    logic rows_done;   // all rows of column issued and captured
    logic last_col;
  } pgtb_sts_t;

endpackage

FILE: rtl/pgtb_datapath.sv
// ----------------------------------------------------------------------------
// pgtb_datapath
// Font store, width/offset tables, cursor state and column assembly.
// ----------------------------------------------------------------------------
module pgtb_datapath import pgtb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  pgtb_cmd_t   cmd,
  output pgtb_sts_t   sts,
  input  logic [4:0]  font_height,
  input  logic [13:0] in_font_address,
  input  logic [3:0]  in_pixel_value,
  input  logic [6:0]  in_glyph_index,
  input  logic [4:0]  in_char_width,
  input  logic [7:0]  in_cursor_x,
  input  logic [7:0]  in_cursor_y,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  output logic [15:0] out_word_address,
  output logic [1:0]  out_nibble_shift,
  output logic [63:0] out_column_pixels,
  output logic        out_last_column,
  output logic        out_bad_char
);

  logic [3:0]  font_mem [FONT_PIXELS];
  logic [4:0]  width_mem [GLYPH_COUNT];
  logic [10:0] offset_mem [GLYPH_COUNT];

  logic [10:0] strip_width_r;
  logic [13:0] tile_word_base_r;
  logic [15:0] line_row_base_r;
  logic [1:0]  nibble_pos_r;
  logic        second_half_r;

  // width load held while the previous glyph's entries are read
  logic [6:0]  wl_idx_r;
  logic [4:0]  wl_w_r;

  logic [4:0]  cur_w_r;
  logic [10:0] cur_off_r;
  logic [4:0]  col_r;
  logic [4:0]  row_r;       // rows issued
  logic [16:0] addr_r;      // row * strip + col + off, up to 17 bits
  logic [3:0]  rd_data_r;
  logic        rd_pend_r;
  logic [3:0]  rd_row_r;
  logic [63:0] pix_r;
  logic [4:0]  eff_h;

  assign eff_h = (font_height > 5'(MAX_ROWS)) ? 5'(MAX_ROWS) : font_height;

  // tables
  logic [4:0] w_sat;
  assign w_sat = (in_char_width > 5'(MAX_CHAR_WIDTH)) ? 5'(MAX_CHAR_WIDTH)
                                                      : in_char_width;
  logic gi_ok;
  assign gi_ok = 8'(wl_idx_r) < 8'(GLYPH_COUNT);

  logic [4:0]  tbl_w_r;
  logic [10:0] tbl_off_r;

  // running sum: previous glyph's offset plus width
  logic [10:0] new_off;
  assign new_off = (wl_idx_r == 7'd0) ? 11'd0 : tbl_off_r + 11'(tbl_w_r);

  logic [6:0] gsel;
  assign gsel = 7'(in_char_code - 8'(FIRST_CODE));

  logic [6:0] tbl_idx;
  assign tbl_idx = cmd.width_look ? (in_glyph_index - 7'd1) : gsel;

  always_ff @(posedge clk) begin
    if (cmd.load_pixel && 32'(in_font_address) < FONT_PIXELS)
      font_mem[in_font_address[FA_W-1:0]] <= in_pixel_value;
    if (cmd.width_look) begin
      wl_idx_r <= in_glyph_index;
      wl_w_r   <= w_sat;
    end
    if (cmd.load_width && gi_ok) begin
      width_mem[wl_idx_r[GI_W-1:0]]  <= wl_w_r;
      offset_mem[wl_idx_r[GI_W-1:0]] <= new_off;
    end
    tbl_w_r   <= width_mem[tbl_idx[GI_W-1:0]];
    tbl_off_r <= offset_mem[tbl_idx[GI_W-1:0]];
    rd_data_r <= font_mem[addr_r[FA_W-1:0]];
  end

  // note the table read is registered, so the entries are ready the cycle after
  // the draw is accepted; the controller waits in S_LOOK before draw_setup
  logic bad;
  assign bad = (in_char_code < 8'(FIRST_CODE)) || (in_char_code > 8'(LAST_CODE)) ||
               (32'(in_char_code) - FIRST_CODE >= GLYPH_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_width_r <= '0;
    end else if (cmd.load_width && gi_ok) begin
      strip_width_r <= new_off + 11'(wl_w_r);
    end
  end

  // cursor
  logic [13:0] adv_base;
  logic        adv_wrap;
  assign adv_base = second_half_r ? (tile_word_base_r + TILE_COLUMN_WORDS - 14'd1)
                                  : (tile_word_base_r + 14'd1);
  assign adv_wrap = second_half_r && (adv_base == SCREEN_WRAP_WORD);

  logic [15:0] cur_base;
  assign cur_base = {8'd0, in_cursor_x[7:3], 3'd0} * 16'd40;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_word_base_r <= '0;
      line_row_base_r  <= '0;
      nibble_pos_r     <= '0;
      second_half_r    <= 1'b0;
    end else if (cmd.set_cursor) begin
      tile_word_base_r <= 14'(cur_base + {15'd0, in_cursor_x[2]});
      nibble_pos_r     <= in_cursor_x[1:0];
      second_half_r    <= in_cursor_x[2];
      line_row_base_r  <= {7'd0, in_cursor_y, 1'b0};
    end else if (cmd.emit) begin
      nibble_pos_r <= nibble_pos_r + 2'd1;
      if (nibble_pos_r == 2'd3) begin
        second_half_r <= ~second_half_r;
        if (adv_wrap) begin
          tile_word_base_r <= '0;
          line_row_base_r  <= line_row_base_r + {10'd0, eff_h, 1'b0} + 16'd4;
        end else begin
          tile_word_base_r <= adv_base;
        end
      end
    end
  end

  // column read engine: issue address, capture the data in the following cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.row_step;
    end
  end

  logic [16:0] addr_nxt;
  assign addr_nxt = addr_r + 17'(strip_width_r);

  logic [16:0] rd_addr_r;
  always_ff @(posedge clk) begin
    if (cmd.draw_setup) begin
      cur_w_r   <= tbl_w_r;
      cur_off_r <= tbl_off_r;
      col_r     <= '0;
    end
    if (cmd.row_start) begin
      row_r  <= '0;
      addr_r <= 17'(cmd.draw_setup ? tbl_off_r : cur_off_r) +
                17'(cmd.draw_setup ? 5'd0 : col_r);
      pix_r  <= '0;
    end else if (cmd.row_step) begin
      row_r     <= row_r + 5'd1;
      addr_r    <= addr_nxt;
      rd_row_r  <= row_r[3:0];
      rd_addr_r <= addr_r;
    end
    if (rd_pend_r && 32'(rd_addr_r) < FONT_PIXELS)
      pix_r[rd_row_r*4 +: 4] <= rd_data_r;
    if (cmd.emit)
      col_r <= col_r + 5'd1;
  end

  assign sts.bad         = bad;
  assign sts.zero_width  = (tbl_w_r == 5'd0);
  assign sts.rows_issued = (row_r >= eff_h);
  assign sts.rows_done   = (row_r >= eff_h) && !rd_pend_r;
  assign sts.last_col    = (col_r + 5'd1 == cur_w_r);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit || cmd.emit_bad;
    end
    out_word_address  <= 16'(tile_word_base_r) + line_row_base_r;
    out_nibble_shift  <= nibble_pos_r;
    out_column_pixels <= cmd.emit_bad ? 64'd0 : pix_r;
    out_last_column   <= cmd.emit_bad ? 1'b1 : sts.last_col;
    out_bad_char      <= cmd.emit_bad;
  end

endmodule

FILE: rtl/pgtb_ctrl.sv
// ----------------------------------------------------------------------------
// pgtb_ctrl
// Sequencer: decodes commands, walks columns and rows of a draw.
// ----------------------------------------------------------------------------
module pgtb_ctrl import pgtb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_func,
  input  pgtb_sts_t  sts,
  output pgtb_cmd_t  cmd,
  output logic       busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_ROWS  = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_NEXT  = 3'd4;
  localparam logic [2:0] S_WLOAD = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       acc;

  assign acc  = start && !busy;
  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (in_func)
            FUNC_LOAD_PIXEL: cmd.load_pixel = 1'b1;
            FUNC_LOAD_WIDTH: begin
              cmd.width_look = 1'b1;
              state_nxt = S_WLOAD;
            end
            FUNC_SET_CURSOR: cmd.set_cursor = 1'b1;
            FUNC_DRAW: begin
              if (sts.bad) cmd.emit_bad = 1'b1;
              else state_nxt = S_LOOK;
            end
            default: ;
          endcase
        end
      end
      S_WLOAD: begin
        cmd.load_width = 1'b1;
        state_nxt = S_IDLE;
      end
      S_LOOK: begin
        if (sts.zero_width) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.draw_setup = 1'b1;
          cmd.row_start  = 1'b1;
          state_nxt = S_ROWS;
        end
      end
      S_ROWS: begin
        if (sts.rows_done) state_nxt = S_EMIT;
        else if (!sts.rows_issued) cmd.row_step = 1'b1;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        state_nxt = sts.last_col ? S_IDLE : S_NEXT;
      end
      S_NEXT: begin
        cmd.row_start = 1'b1;
        state_nxt = S_ROWS;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

FILE: rtl/proportional_glyph_tile_blitter.sv
// ----------------------------------------------------------------------------
// proportional_glyph_tile_blitter
// Draws proportional 4bpp glyphs from a font strip into tiled video words.
// ----------------------------------------------------------------------------
// Pixel loads and cursor sets are taken in the accept cycle and leave busy low.
// A width load holds busy for one cycle while the previous glyph's entries are
// read. A draw holds busy while it latches the table entries, then per column
// issues the pixel reads, one per row of font_height clamped to 16 and none at
// height zero, through the single font read port, waits for the last read to
// land, decides, presents the column and, but for the last column, starts the
// next. Each column leaves on out_valid in the cycle after it is formed and
// the receiver cannot stall it.
// A bad code answers the cycle after accept; a zero-width glyph gives nothing.
module proportional_glyph_tile_blitter import pgtb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [13:0] in_font_address,
  input  logic [3:0]  in_pixel_value,
  input  logic [6:0]  in_glyph_index,
  input  logic [4:0]  in_char_width,
  input  logic [7:0]  in_cursor_x,
  input  logic [7:0]  in_cursor_y,
  input  logic [7:0]  in_char_code,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  output logic        out_valid,
  output logic [15:0] out_word_address,
  output logic [1:0]  out_nibble_shift,
  output logic [63:0] out_column_pixels,
  output logic        out_last_column,
  output logic        out_bad_char
);

  pgtb_cmd_t  cmd;
  pgtb_sts_t  sts;
  logic [4:0] font_height_r;
  logic [7:0] char_r;
  logic [7:0] char_sel;

  always_ff @(posedge clk) begin
    if (!rst_n)      font_height_r <= 5'd8;
    else if (cfg_we) font_height_r <= cfg_wdata;
  end

  // hold the character for the table lookup cycle
  always_ff @(posedge clk) begin
    if (start && !busy) char_r <= in_char_code;
  end
  assign char_sel = busy ? char_r : in_char_code;

  pgtb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_func(in_func),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  pgtb_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .font_height(font_height_r),
    .in_font_address(in_font_address), .in_pixel_value(in_pixel_value),
    .in_glyph_index(in_glyph_index), .in_char_width(in_char_width),
    .in_cursor_x(in_cursor_x), .in_cursor_y(in_cursor_y),
    .in_char_code(char_sel),
    .out_valid(out_valid), .out_word_address(out_word_address),
    .out_nibble_shift(out_nibble_shift), .out_column_pixels(out_column_pixels),
    .out_last_column(out_last_column), .out_bad_char(out_bad_char)
  );

`ifndef SYNTHESIS
  a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_char |-> out_last_column && out_column_pixels == 64'd0)
    else $error("bad result not final");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.load_pixel, cmd.load_width, cmd.set_cursor, cmd.emit,
                cmd.emit_bad}) <= 1)
    else $error("conflicting commands");
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> busy)
    else $error("column emitted while idle");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives font, width, cursor and draw beats into the glyph blitter and checks
// every column result against a cycle-free model of the tiled write pattern.
// ----------------------------------------------------------------------------
module testbench;
  import pgtb_pkg::*;

  typedef struct packed {
    logic [1:0]  func;
    logic [13:0] font_address;
    logic [3:0]  pixel_value;
    logic [6:0]  glyph_index;
    logic [4:0]  char_width;
    logic [7:0]  cursor_x;
    logic [7:0]  cursor_y;
    logic [7:0]  char_code;
  } blit_cmd_t;

  typedef struct packed {
    logic [15:0] word_address;
    logic [1:0]  nibble_shift;
    logic [63:0] column_pixels;
    logic        last_column;
    logic        bad_char;
  } column_res_t;

  localparam int CYCLE_LIMIT = 3000000;
  // only glyphs 0..5 get widths; their reads stay below FILL_PIXELS
  localparam int DRAWN_GLYPHS = 6;
  localparam int DRAW_LAST    = FIRST_CODE + DRAWN_GLYPHS - 1;
  localparam int FILL_PIXELS  = 128;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;
  logic        out_valid;
  blit_cmd_t   cmd = '0;
  column_res_t res;

  // model state
  logic [3:0]  font_mem [FONT_PIXELS];
  logic [4:0]  glyph_w [GLYPH_COUNT];
  logic [10:0] glyph_off [GLYPH_COUNT];
  logic [10:0] strip_w = '0;
  logic [13:0] tile_base = '0;
  logic [15:0] row_base = '0;
  logic [1:0]  nib = '0;
  logic        half = 1'b0;
  logic [4:0]  height = 5'd8;

  column_res_t pending_cols [$];
  int          errors = 0;
  int          cycles = 0;
  bit          no_idle = 1'b0;

  always #5 clk = ~clk;

  proportional_glyph_tile_blitter u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(cmd.func), .in_font_address(cmd.font_address),
    .in_pixel_value(cmd.pixel_value), .in_glyph_index(cmd.glyph_index),
    .in_char_width(cmd.char_width), .in_cursor_x(cmd.cursor_x),
    .in_cursor_y(cmd.cursor_y), .in_char_code(cmd.char_code),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_word_address(res.word_address),
    .out_nibble_shift(res.nibble_shift), .out_column_pixels(res.column_pixels),
    .out_last_column(res.last_column), .out_bad_char(res.bad_char)
  );

  function automatic int eff_height();
    return (height > MAX_ROWS) ? MAX_ROWS : int'(height);
  endfunction

  function automatic column_res_t cursor_col(logic [63:0] pix, logic last, logic bad);
    column_res_t r;
    r.word_address  = 16'(tile_base + row_base);
    r.nibble_shift  = nib;
    r.column_pixels = pix;
    r.last_column   = last;
    r.bad_char      = bad;
    return r;
  endfunction

  function automatic void step_cursor();
    nib = nib + 2'd1;
    if (nib == 2'd0) begin
      if (half) begin
        tile_base = tile_base + TILE_COLUMN_WORDS - 14'd1;
        if (tile_base == SCREEN_WRAP_WORD) begin
          tile_base = '0;
          row_base  = row_base + 16'(eff_height() * 2 + 4);
        end
      end else begin
        tile_base = tile_base + 14'd1;
      end
      half = ~half;
    end
  endfunction

  function automatic void predict_beat(blit_cmd_t c);
    int gi, w, off, x, n, addr;
    logic [63:0] pix;
    case (c.func)
      FUNC_LOAD_PIXEL: font_mem[c.font_address] = c.pixel_value;
      FUNC_LOAD_WIDTH: begin
        gi = c.glyph_index;
        if (gi < GLYPH_COUNT) begin
          w = (c.char_width > MAX_CHAR_WIDTH) ? MAX_CHAR_WIDTH : int'(c.char_width);
          off = (gi > 0) ? int'(11'(glyph_off[gi-1] + glyph_w[gi-1])) : 0;
          glyph_w[gi]   = 5'(w);
          glyph_off[gi] = 11'(off);
          strip_w       = 11'(off + w);
        end
      end
      FUNC_SET_CURSOR: begin
        x = c.cursor_x;
        n = x & 7;
        tile_base = 14'((x - n) * 40 + ((n > 3) ? 1 : 0));
        nib  = 2'(n);
        half = (n > 3);
        row_base = {7'd0, c.cursor_y, 1'b0};
      end
      default: begin
        if (c.char_code < FIRST_CODE || c.char_code > LAST_CODE) begin
          pending_cols.push_back(cursor_col('0, 1'b1, 1'b1));
        end else begin
          gi = c.char_code - FIRST_CODE;
          w = glyph_w[gi];
          off = glyph_off[gi];
          for (int col = 0; col < w; col++) begin
            pix = '0;
            for (int row = 0; row < eff_height(); row++) begin
              addr = row * int'(strip_w) + col + off;
              if (addr < FONT_PIXELS) pix[4*row +: 4] = font_mem[addr];
            end
            pending_cols.push_back(cursor_col(pix, col + 1 == w, 1'b0));
            step_cursor();
          end
        end
      end
    endcase
  endfunction

  // beats are presented at the falling edge and taken when busy is low
  task automatic send_beat(blit_cmd_t c);
    @(negedge clk);
    if (!no_idle && $urandom_range(99) < 20) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    cmd   = c;
    start = 1'b1;
    do @(posedge clk); while (busy);
    predict_beat(c);
  endtask

  function automatic blit_cmd_t rand_cmd(logic [1:0] f);
    blit_cmd_t c;
    c = blit_cmd_t'(56'({$urandom, $urandom}));
    c.func = f;
    return c;
  endfunction

  task automatic send_pixel(int a, int v);
    blit_cmd_t c = rand_cmd(FUNC_LOAD_PIXEL);
    c.font_address = 14'(a);
    c.pixel_value  = 4'(v);
    send_beat(c);
  endtask

  task automatic send_width(int gi, int w);
    blit_cmd_t c = rand_cmd(FUNC_LOAD_WIDTH);
    c.glyph_index = 7'(gi);
    c.char_width  = 5'(w);
    send_beat(c);
  endtask

  task automatic send_cursor(int x, int y);
    blit_cmd_t c = rand_cmd(FUNC_SET_CURSOR);
    c.cursor_x = 8'(x);
    c.cursor_y = 8'(y);
    send_beat(c);
  endtask

  task automatic send_draw(int code);
    blit_cmd_t c = rand_cmd(FUNC_DRAW);
    c.char_code = 8'(code);
    send_beat(c);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (pending_cols.size() != 0 || busy) @(posedge clk);
    repeat (25) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_height(int h);
    wait_idle();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = 5'(h);
    @(negedge clk);
    cfg_we = 1'b0;
    height = 5'(h);
  endtask

  // every pixel a draw can reach is written up front
  task automatic test_font_fill();
    no_idle = 1'b1;
    for (int a = 0; a < FILL_PIXELS; a++) send_pixel(a, $urandom_range(15));
    no_idle = 1'b0;
  endtask

  // strip stride ends at 5 after the last reload; wide glyphs sit past it
  task automatic test_width_table();
    send_width(0, 2);
    send_width(1, 0);
    send_width(2, 3);
    send_width(3, 31);
    send_width(4, 17);
    send_width(5, 1);
    send_width(GLYPH_COUNT, 5);
    send_width(127, 31);
    send_width(2, 3);
  endtask

  task automatic test_directed();
    send_cursor(0, 0);
    send_draw(32);
    send_draw(33);
    send_draw(DRAW_LAST);
    send_draw(0);
    send_draw(31);
    send_draw(128);
    send_draw(255);
    send_cursor(239, 159);
    send_draw(34);
    send_cursor(255, 255);
    send_draw(35);
    send_cursor(4, 1);
    send_draw(32);
    // half-tile start in the last tile column forces a line wrap
    send_cursor(236, 10);
    send_draw(36);
    send_draw(DRAW_LAST);
    send_pixel(FONT_PIXELS - 1, 15);
    send_pixel(0, 0);
    send_draw(32);
  endtask

  task automatic test_heights();
    int hs [6] = '{1, 16, 0, 31, 5, 8};
    foreach (hs[i]) begin
      write_height(hs[i]);
      send_cursor(232, 0);
      send_draw(32);
      send_draw($urandom_range(FIRST_CODE, DRAW_LAST));
    end
  endtask

  task automatic test_random(int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      no_idle = (i >= n / 3 && i < n / 2);
      if (i == n / 2) write_height($urandom_range(1, 16));
      sel = $urandom_range(99);
      if (sel < 45)      send_draw($urandom_range(FIRST_CODE, DRAW_LAST));
      else if (sel < 52) send_draw($urandom_range(1) ? $urandom_range(FIRST_CODE - 1)
                                                     : $urandom_range(LAST_CODE + 1, 255));
      else if (sel < 72) send_cursor($urandom_range(255), $urandom_range(255));
      else if (sel < 87) send_pixel($urandom_range(FILL_PIXELS - 1), $urandom_range(15));
      else if (sel < 90) send_width($urandom_range(GLYPH_COUNT, 127), $urandom_range(31));
      else               send_width($urandom_range(2), $urandom_range(2));
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    column_res_t exp_col;
    if (rst_n && out_valid) begin
      if (pending_cols.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        exp_col = pending_cols.pop_front();
        if (res.word_address !== exp_col.word_address) begin
          $error("word_address exp %h got %h", exp_col.word_address, res.word_address);
          errors++;
        end
        if (res.nibble_shift !== exp_col.nibble_shift) begin
          $error("nibble_shift exp %0d got %0d", exp_col.nibble_shift, res.nibble_shift);
          errors++;
        end
        if (res.column_pixels !== exp_col.column_pixels) begin
          $error("column_pixels exp %h got %h", exp_col.column_pixels, res.column_pixels);
          errors++;
        end
        if (res.last_column !== exp_col.last_column) begin
          $error("last_column exp %b got %b", exp_col.last_column, res.last_column);
          errors++;
        end
        if (res.bad_char !== exp_col.bad_char) begin
          $error("bad_char exp %b got %b", exp_col.bad_char, res.bad_char);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    test_font_fill();
    test_width_table();
    test_directed();
    test_heights();
    test_random(136);
    wait_idle();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
